// ===== design/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp_pkg: shared types and constants for the 3x3 local binary pattern block
// Field widths, configuration register indexes and the position record that
// the scan counters hand to the pipeline.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int PIXEL_W = 8;
   localparam int CODE_W  = 8;
   localparam int POS_W   = 10;
   localparam int CFG_W   = 11;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;
   localparam logic [CFG_W-1:0] MIN_DIM            = 11'd3;
   localparam logic [CFG_W-1:0] MAX_HEIGHT         = 11'd1024;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [POS_W-1:0]   pos_type;

   // Where the incoming pixel sits, as seen by the output stage.
   typedef struct packed {
      logic    has_code;
      logic    frame_end;
      pos_type centre_row;
      pos_type centre_column;
   } scan_pos_type;

endpackage

// ===== design/lbp_if.sv =====
// ----------------------------------------------------------------------------
// lbp_if: pixel and pattern channels
// Valid/ready channels; an item moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface lbp_req_if
   import lbp_pkg::*;
();
   logic      valid;
   logic      ready;
   pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp_rsp_if
   import lbp_pkg::*;
();
   logic     valid;
   logic     ready;
   code_type pattern_code;
   pos_type  centre_row;
   pos_type  centre_column;
   logic     frame_end;

   modport source (output valid, output pattern_code, output centre_row,
                   output centre_column, output frame_end, input ready);
   modport sink   (input valid, input pattern_code, input centre_row,
                   input centre_column, input frame_end, output ready);
endinterface

// ===== design/lbp_line_buf.sv =====
// ----------------------------------------------------------------------------
// lbp_line_buf: two line stores
// The middle store takes the incoming pixel at the read address; the upper
// store takes the old middle entry once the item moves on.
// ----------------------------------------------------------------------------
module lbp_line_buf
   import lbp_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  pixel_type     wr_pixel,
   input  logic          up_wr_en,
   input  logic [AW-1:0] up_wr_addr,
   output pixel_type     top_q,
   output pixel_type     mid_q
);

   pixel_type upper_mem [DEPTH];
   pixel_type middle_mem [DEPTH];
   pixel_type top_ff;
   pixel_type mid_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_ff                <= upper_mem[rd_addr];
         mid_ff                <= middle_mem[rd_addr];
         middle_mem[rd_addr]   <= wr_pixel;
      end
   end

   // The row above moves up once its old value has been read out.
   always_ff @(posedge clock) begin
      if (up_wr_en) begin
         upper_mem[up_wr_addr] <= mid_ff;
      end
   end

   assign top_q = top_ff;
   assign mid_q = mid_ff;

endmodule

// ===== design/lbp_scan.sv =====
// ----------------------------------------------------------------------------
// lbp_scan: frame geometry registers and raster counters
// Holds the width and height registers, clamps them and tracks the column
// and row of the next pixel.
// ----------------------------------------------------------------------------
module lbp_scan
   import lbp_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int CW        = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 advance,
   output logic [CW-1:0]        column,
   output scan_pos_type         pos
);

   localparam int WW = ((CW > CFG_W) ? CW : CFG_W) + 1;

   logic [CFG_W-1:0] frame_width_ff;
   logic [CFG_W-1:0] frame_height_ff;
   logic [CW-1:0]    col_ff;
   logic [CW-1:0]    col_in;
   pos_type          row_ff;
   pos_type          row_in;
   logic [WW-1:0]    fw_ext;
   logic [WW-1:0]    width_eff;
   logic [CFG_W-1:0] height_eff;
   logic             last_col;
   logic             last_row;
   logic [CW-1:0]    col_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      fw_ext = WW'(frame_width_ff);
      priority if (fw_ext < WW'(MIN_DIM)) begin
         width_eff = WW'(MIN_DIM);
      end else if (fw_ext > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = fw_ext;
      end
      priority if (frame_height_ff < MIN_DIM) begin
         height_eff = MIN_DIM;
      end else if (frame_height_ff > MAX_HEIGHT) begin
         height_eff = MAX_HEIGHT;
      end else begin
         height_eff = frame_height_ff;
      end
   end

   // A counter at or past the last position wraps, so a narrower frame
   // written between frames takes effect cleanly.
   assign last_col = WW'(col_ff) >= (width_eff - WW'(1));
   assign last_row = CFG_W'(row_ff) >= (height_eff - CFG_W'(1));
   assign col_m1   = col_ff - CW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign column            = col_ff;
   assign pos.has_code      = (row_ff >= POS_W'(2)) && (col_ff >= CW'(2));
   assign pos.frame_end     = last_col && last_row;
   assign pos.centre_row    = row_ff - POS_W'(1);
   assign pos.centre_column = POS_W'(col_m1);

endmodule

// ===== design/lbp_window.sv =====
// ----------------------------------------------------------------------------
// lbp_window: 3x3 window and pattern compare
// Shifts a new column into the window and codes the window that results.
// ----------------------------------------------------------------------------
module lbp_window
   import lbp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_en,
   input  pixel_type top_px,
   input  pixel_type mid_px,
   input  pixel_type bot_px,
   output code_type  code_next
);

   pixel_type win_ff [9];
   pixel_type win_in [9];
   pixel_type centre;

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = top_px;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = mid_px;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = bot_px;
   end

   // Neighbours row by row from the top left; the centre is skipped.
   assign centre = win_in[4];
   assign code_next = {win_in[0] >= centre, win_in[1] >= centre,
                       win_in[2] >= centre, win_in[3] >= centre,
                       win_in[5] >= centre, win_in[6] >= centre,
                       win_in[7] >= centre, win_in[8] >= centre};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

// ===== design/local_binary_pattern_3x3.sv =====
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3: 8-neighbor LBP over a raster pixel stream
//
//   channel   dir   handshake              payload
//   req_chan  in    valid/ready            pixel
//   rsp_chan  out   valid/ready            pattern_code, centre_row,
//                                          centre_column, frame_end
//   csr_*     in    write enable only      csr_index, csr_wdata
//
// One pixel per clock while the result is not stalled. An item waits in the
// input stage, where the line stores are read, and its code moves into the
// result register when it leaves. Pixels in the first two rows or columns give
// no result and never wait for the output. A stalled result holds the input
// stage; a new pixel is taken whenever the input stage empties in the same
// cycle. Reset restores 640 x 480 and restarts the raster at row 0, column 0.
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3
   import lbp_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   lbp_req_if.sink              req_chan,
   lbp_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic          accept;
   logic          s1_go;
   logic          out_free;
   logic [CW-1:0] column;
   scan_pos_type  pos;
   pixel_type     top_q;
   pixel_type     mid_q;
   code_type      code_next;

   logic          s1_valid_ff;
   logic          s1_valid_in;
   pixel_type     s1_pixel_ff;
   logic [CW-1:0] s1_col_ff;
   scan_pos_type  s1_pos_ff;

   logic          out_valid_ff;
   logic          out_valid_in;
   code_type      out_code_ff;
   pos_type       out_row_ff;
   pos_type       out_col_ff;
   logic          out_end_ff;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign s1_go    = s1_valid_ff && (out_free || !s1_pos_ff.has_code);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign accept   = req_chan.valid && req_chan.ready;

   lbp_scan #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .column    (column),
      .pos       (pos)
   );

   lbp_line_buf #(.DEPTH(MAX_WIDTH), .AW(CW)) u_line_buf (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (column),
      .wr_pixel   (req_chan.pixel),
      .up_wr_en   (s1_go),
      .up_wr_addr (s1_col_ff),
      .top_q      (top_q),
      .mid_q      (mid_q)
   );

   lbp_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_go),
      .top_px    (top_q),
      .mid_px    (mid_q),
      .bot_px    (s1_pixel_ff),
      .code_next (code_next)
   );

   always_comb begin
      priority if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      priority if (s1_go && s1_pos_ff.has_code) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_chan.pixel;
         s1_col_ff   <= column;
         s1_pos_ff   <= pos;
      end
      if (s1_go && s1_pos_ff.has_code) begin
         out_code_ff <= code_next;
         out_row_ff  <= s1_pos_ff.centre_row;
         out_col_ff  <= s1_pos_ff.centre_column;
         out_end_ff  <= s1_pos_ff.frame_end;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pattern_code  = out_code_ff;
   assign rsp_chan.centre_row    = out_row_ff;
   assign rsp_chan.centre_column = out_col_ff;
   assign rsp_chan.frame_end     = out_end_ff;

endmodule

// ===== test/local_binary_pattern_3x3_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3_test: self-checking bench for the 3x3 LBP block
// Streams grey pixels through the valid/ready input channel and predicts the
// pattern code, centre position and end-of-frame flag of every interior
// pixel. Frame sizes change between bursts, including mid-frame, with both
// channel sides idling at random.
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3_test;
   import lbp_pkg::*;

   localparam int          HALF_PERIOD   = 5;
   localparam int          LINE_DEPTH    = 1024;
   localparam int unsigned RANDOM_ITEMS  = 580;
   localparam int unsigned WIDE_ITEMS    = 150;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned MODEST_W      = 12;
   localparam int unsigned MODEST_H      = 8;

   typedef enum int unsigned {MIX_UNIFORM, MIX_BAND, MIX_EXTREME} pixel_mix_type;

   typedef struct packed {
      code_type code;
      pos_type  row;
      pos_type  column;
      logic     last;
   } pattern_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   lbp_req_if req_chan ();
   lbp_rsp_if rsp_chan ();

   local_binary_pattern_3x3 i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Scan state of the expected behavior.
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   pixel_type        upper_row  [LINE_DEPTH];
   pixel_type        middle_row [LINE_DEPTH];
   pixel_type        grid       [9];
   pos_type          col_pos;
   pos_type          row_pos;

   pattern_result_type awaited_codes [$];
   pattern_result_type next_code;
   pixel_type          pending_pixels [$];
   int unsigned        pixels_queued;
   int unsigned        pixels_taken = 0;
   int unsigned        mismatches = 0;
   int unsigned        cycle_count = 0;
   int unsigned        req_gap;
   int unsigned        rsp_hold;
   bit                 req_eager;
   bit                 rsp_eager;

   // Two hand-built frames: alternating neighbors around a mid-grey centre,
   // then a white centre with one equal neighbor and the darkest values.
   pixel_type directed_pixels [18] = '{
      8'd128, 8'd127, 8'd128,  8'd127, 8'd128, 8'd128,  8'd127, 8'd128, 8'd127,
      8'd255, 8'd0,   8'd254,  8'd1,   8'd255, 8'd253,  8'd2,   8'd128, 8'd0
   };

   always #HALF_PERIOD clock = ~clock;

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] value,
                                             input int unsigned top);
      if (value < MIN_DIM) return 32'(MIN_DIM);
      if (value > top) return top;
      return 32'(value);
   endfunction

   function automatic int unsigned draw_wait(input bit eager);
      return eager ? 0 : $urandom_range(0, 19);
   endfunction

   // Shifts one pixel into the line stores and window; an interior centre
   // yields the code that the block must return for it.
   function automatic void code_for_pixel(input pixel_type pixel);
      int unsigned        w;
      int unsigned        h;
      pixel_type          top;
      pixel_type          mid;
      logic               last_col;
      logic               last_row;
      pattern_result_type entry;
      w = clamp_dim(width_reg, LINE_DEPTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      top = upper_row[col_pos];
      mid = middle_row[col_pos];
      last_col = (col_pos >= w - 1);
      last_row = (row_pos >= h - 1);
      upper_row[col_pos] = mid;
      middle_row[col_pos] = pixel;
      grid[0] = grid[1];
      grid[1] = grid[2];
      grid[2] = top;
      grid[3] = grid[4];
      grid[4] = grid[5];
      grid[5] = mid;
      grid[6] = grid[7];
      grid[7] = grid[8];
      grid[8] = pixel;
      if (row_pos >= 2 && col_pos >= 2) begin
         entry.code = '0;
         for (int k = 0; k < 9; k++) begin
            if (k != 4) entry.code = {entry.code[CODE_W-2:0], grid[k] >= grid[4]};
         end
         entry.row = row_pos - POS_W'(1);
         entry.column = col_pos - POS_W'(1);
         entry.last = last_col && last_row;
         awaited_codes.push_back(entry);
      end
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : row_pos + POS_W'(1);
      end else begin
         col_pos = col_pos + POS_W'(1);
      end
   endfunction

   function automatic void report_field(input string field, input logic [POS_W-1:0] want,
                                        input logic [POS_W-1:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
   endfunction

   function automatic logic [CFG_W-1:0] pick_dim(input bit shrink, input int unsigned modest);
      if (shrink) return CFG_W'($urandom_range(3, modest));
      case ($urandom_range(0, 5))
         0: return CFG_W'($urandom_range(0, 2));
         1: return CFG_W'($urandom_range(1025, 2047));
         2: return MAX_HEIGHT;
         default: return CFG_W'($urandom_range(3, modest));
      endcase
   endfunction

   task automatic queue_pixel(input pixel_type pixel);
      pending_pixels.push_back(pixel);
      pixels_queued++;
   endtask

   task automatic feed(input int unsigned count, input pixel_mix_type mix);
      pixel_type base;
      base = PIXEL_W'($urandom_range(0, 255));
      repeat (count) begin
         case (mix)
            MIX_UNIFORM: queue_pixel(PIXEL_W'($urandom_range(0, 255)));
            MIX_BAND:    queue_pixel(base + PIXEL_W'($urandom_range(0, 2)));
            default:     queue_pixel(PIXEL_W'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                                                   : $urandom_range(0, 1)));
         endcase
      end
   endtask

   // Returns once every pixel is taken, every code has arrived and the input
   // stage has had time to finish a pixel that produces no code.
   task automatic settle();
      do begin
         @(posedge clock);
      end while (pixels_taken != pixels_queued || awaited_codes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) begin
         width_reg = value;
      end else begin
         height_reg = value;
      end
   endtask

   // Pixel driver.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.pixel <= '0;
         req_gap = 0;
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         foreach (grid[i]) grid[i] = '0;
         col_pos = '0;
         row_pos = '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            code_for_pixel(req_chan.pixel);
            pixels_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               req_chan.valid <= 1'b1;
               req_chan.pixel <= pending_pixels.pop_front();
               req_gap = draw_wait(req_eager);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Pattern monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_codes.size() == 0) begin
               $display("%0t: unexpected code, expected none, got %h at row %0d column %0d",
                        $time, rsp_chan.pattern_code, rsp_chan.centre_row,
                        rsp_chan.centre_column);
               mismatches++;
            end else begin
               next_code = awaited_codes.pop_front();
               if (rsp_chan.pattern_code !== next_code.code) begin
                  report_field("pattern_code", POS_W'(next_code.code),
                               POS_W'(rsp_chan.pattern_code));
               end
               if (rsp_chan.centre_row !== next_code.row) begin
                  report_field("centre_row", next_code.row, rsp_chan.centre_row);
               end
               if (rsp_chan.centre_column !== next_code.column) begin
                  report_field("centre_column", next_code.column, rsp_chan.centre_column);
               end
               if (rsp_chan.frame_end !== next_code.last) begin
                  report_field("frame_end", POS_W'(next_code.last),
                               POS_W'(rsp_chan.frame_end));
               end
            end
            rsp_hold = draw_wait(rsp_eager);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_chan.ready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int unsigned      count;
      int unsigned      random_sent;
      logic [CFG_W-1:0] value;
      bit               shrink;

      csr_wr_en <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      pixels_queued = 0;
      random_sent = 0;
      req_eager = 1'b0;
      rsp_eager = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Out-of-range sizes clamp to the smallest 3x3 frame.
      write_reg(CSR_FRAME_WIDTH, 11'd0);
      write_reg(CSR_FRAME_HEIGHT, 11'd2);
      foreach (directed_pixels[i]) queue_pixel(directed_pixels[i]);
      settle();

      // Part of a row at the widest width, with the height register at zero;
      // the first random burst then narrows the frame past the scan position.
      write_reg(CSR_FRAME_WIDTH, 11'h7FF);
      write_reg(CSR_FRAME_HEIGHT, 11'd0);
      feed(WIDE_ITEMS, MIX_UNIFORM);
      settle();

      // Bursts of random length; each pause lands anywhere in the frame, so
      // size changes often hit a scan position beyond the new last row/column.
      while (random_sent < RANDOM_ITEMS) begin
         shrink = clamp_dim(width_reg, LINE_DEPTH) > MODEST_W;
         if (shrink || $urandom_range(0, 2) == 0) begin
            value = pick_dim(shrink, MODEST_W);
            // Widening past row 0 would read line store columns never written.
            if (row_pos == 0 ||
                clamp_dim(value, LINE_DEPTH) <= clamp_dim(width_reg, LINE_DEPTH)) begin
               write_reg(CSR_FRAME_WIDTH, value);
            end
         end
         shrink = clamp_dim(height_reg, MAX_HEIGHT) > MODEST_H;
         if (shrink || $urandom_range(0, 2) == 0) begin
            write_reg(CSR_FRAME_HEIGHT, pick_dim(shrink, MODEST_H));
         end
         if (clamp_dim(width_reg, LINE_DEPTH) > MODEST_W ||
             clamp_dim(height_reg, MAX_HEIGHT) > MODEST_H) begin
            count = $urandom_range(4, 40);
         end else begin
            count = $urandom_range(1, 60);
         end
         req_eager = ($urandom_range(0, 3) == 0);
         rsp_eager = ($urandom_range(0, 3) == 0);
         feed(count, pixel_mix_type'($urandom_range(0, 2)));
         random_sent += count;
         settle();
      end

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== local_binary_pattern_3x3.f =====
design/lbp_pkg.sv
design/lbp_if.sv
design/lbp_line_buf.sv
design/lbp_scan.sv
design/lbp_window.sv
design/local_binary_pattern_3x3.sv
test/local_binary_pattern_3x3_test.sv
